// ===== sv/hll_interface_flux_top_macros.svh =====
// Assertion macros shared by the HLL interface flux RTL
`ifndef HLL_INTERFACE_FLUX_TOP_MACROS_SVH
`define HLL_INTERFACE_FLUX_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Plain property, clocked on the rising edge and disabled during reset
`define HIF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Same-cycle implication
`define HIF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define HIF_ASSERT(lbl, clk, rst_n, prop, msg)
`define HIF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== sv/hif_pkg.sv =====
// Shared types, constants and helpers of the HLL interface flux block
package hif_pkg;

    localparam int Q_ONE = 65536;
    localparam logic [17:0] GAMMA_RESET = 18'd91750;
    localparam logic signed [31:0] INT32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;

    // Which flux the interface takes
    typedef enum logic [1:0] {
        UPW_LEFT  = 2'd0,
        UPW_HLL   = 2'd1,
        UPW_RIGHT = 2'd2
    } upwind_t;

    // Primitive state, sound speed and physical flux of one cell
    typedef struct packed {
        logic signed [31:0] vel;
        logic signed [31:0] snd;
        logic signed [31:0] mom;
        logic [30:0]        rho;
        logic [30:0]        en;
        logic signed [31:0] f1;
        logic signed [31:0] f2;
        logic               bad;
    } side_t;

    // One result transaction
    typedef struct packed {
        logic signed [31:0] mass;
        logic signed [31:0] momentum;
        logic signed [31:0] energy;
        logic signed [31:0] slow;
        logic signed [31:0] fast;
        upwind_t            kase;
        logic               bad;
    } result_t;

    // Clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [71:0] x);
        logic [40:0] hi;
        hi = x[71:31];
        if (hi == '0 || hi == '1)
        begin
            return x[31:0];
        end
        else if (x[71])
        begin
            return INT32_MIN;
        end
        else
        begin
            return INT32_MAX;
        end
    endfunction

endpackage

// ===== sv/hll_interface_flux_top.sv =====
// HLL interface flux: top level with stream ports, gamma register and output register
//
// Takes one interface (conserved states of the left and right cell) per transaction and
// returns the HLL flux and both wave-speed bounds, Q16.16 and saturated, plus the upwind
// case and a bad-state flag. The datapath is fully pipelined: a new transaction is
// accepted on every cycle unless the result side stalls. The pipeline has the bit-serial
// stages: the velocity divider (48 stages), the gamma*p/rho divider (50), the sound-speed
// square root (31) and the flux weight dividers (32), plus twelve stages of multiplies
// and sums and the output register. A stall on the result side freezes the whole
// pipeline; nothing is dropped. The user must write gamma_ratio on the cfg channel only
// while the pipeline is empty; the block does not enforce it. gamma_ratio resets to 1.4.
`include "hll_interface_flux_top_macros.svh"

module hll_interface_flux_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // left_density, left_momentum, left_energy, right_density, right_momentum,
    // right_energy (31, 32, 31, 31, 32, 31 bits), zero pad
    input  logic [191:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // mass_flux, momentum_flux, energy_flux, slow_wave_speed, fast_wave_speed (32 bits each)
    output logic [159:0] m_tdata,
    // upwind_case (2 bits), bad_state (1 bit)
    output logic [2:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [17:0]  cfg_data
);

    logic             ce;
    logic [17:0]      gamma_reg;
    logic             lvld, rvld, cvld;
    hif_pkg::side_t   lside, rside;
    hif_pkg::result_t cres, res_reg;
    logic             out_vld_reg;

    // pipeline advances unless a result is held
    assign ce        = !out_vld_reg || m_tready;
    assign s_tready  = ce;
    assign cfg_ready = 1'b1;

    // gamma register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg <= hif_pkg::GAMMA_RESET;
        end
        else if (cfg_valid)
        begin
            gamma_reg <= cfg_data;
        end
    end

    hif_side u_left (
        .clk    (clk),
        .rst_n  (rst_n),
        .ce     (ce),
        .in_vld (s_tvalid),
        .gamma  (gamma_reg),
        .rho    (s_tdata[30:0]),
        .mom    ($signed(s_tdata[62:31])),
        .en     (s_tdata[93:63]),
        .out_vld(lvld),
        .side   (lside)
    );

    hif_side u_right (
        .clk    (clk),
        .rst_n  (rst_n),
        .ce     (ce),
        .in_vld (s_tvalid),
        .gamma  (gamma_reg),
        .rho    (s_tdata[124:94]),
        .mom    ($signed(s_tdata[156:125])),
        .en     (s_tdata[187:157]),
        .out_vld(rvld),
        .side   (rside)
    );

    hif_comb u_comb (
        .clk    (clk),
        .rst_n  (rst_n),
        .ce     (ce),
        .in_vld (lvld & rvld),
        .left   (lside),
        .right  (rside),
        .out_vld(cvld),
        .res    (cres)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (ce)
        begin
            out_vld_reg <= cvld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            res_reg <= cres;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {res_reg.fast, res_reg.slow, res_reg.energy, res_reg.momentum,
                       res_reg.mass};
    assign m_tuser  = {res_reg.bad, res_reg.kase};

    // consistency of the upwind case with the wave speeds
    `HIF_ASSERT_IMPL(a_left_slow, clk, rst_n, out_vld_reg && res_reg.kase == hif_pkg::UPW_LEFT, res_reg.slow >= 32'sd0, "left flux chosen with negative slow speed")
    `HIF_ASSERT_IMPL(a_right_fast, clk, rst_n, out_vld_reg && res_reg.kase == hif_pkg::UPW_RIGHT, res_reg.fast < 32'sd0, "right flux chosen with non-negative fast speed")
    `HIF_ASSERT_IMPL(a_hll_span, clk, rst_n, out_vld_reg && res_reg.kase == hif_pkg::UPW_HLL, res_reg.slow < 32'sd0 && res_reg.fast >= 32'sd0, "HLL flux outside its wave fan")
    `HIF_ASSERT(a_speed_order, clk, rst_n, out_vld_reg |-> res_reg.fast >= res_reg.slow, "fast wave speed below slow wave speed")

endmodule

// ===== sv/hif_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a tag line
module hif_div #(
    parameter int NW = 48,
    parameter int DW = 31,
    parameter int QW = 48,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          ce,
    input  logic          in_vld,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] tag_in,
    output logic          out_vld,
    output logic [QW-1:0] quo,
    output logic [SW-1:0] tag_out
);

    localparam int RW = DW + 1;

    logic [NW+RW-1:0] num_ext;
    logic [RW-1:0]    rem_reg [QW];
    logic [QW-1:0]    quo_reg [QW];
    logic [NW-1:0]    num_reg [QW];
    logic [DW-1:0]    den_reg [QW];
    logic [SW-1:0]    tag_reg [QW];
    logic             vld_reg [QW];

    // upper numerator bits form the starting remainder
    assign num_ext = {{RW{1'b0}}, num};

    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        localparam int B = QW - 1 - i;
        logic [RW-1:0] rem_in;
        logic [QW-1:0] quo_in;
        logic [NW-1:0] num_in;
        logic [DW-1:0] den_in;
        logic [SW-1:0] tag_s;
        logic          vld_in;
        logic [RW-1:0] trial;
        logic [RW-1:0] rem_next;
        logic [QW-1:0] quo_next;
        logic          fits;

        if (i == 0)
        begin : g_first
            assign rem_in = num_ext[QW +: RW];
            assign quo_in = '0;
            assign num_in = num;
            assign den_in = den;
            assign tag_s  = tag_in;
            assign vld_in = in_vld;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign quo_in = quo_reg[i-1];
            assign num_in = num_reg[i-1];
            assign den_in = den_reg[i-1];
            assign tag_s  = tag_reg[i-1];
            assign vld_in = vld_reg[i-1];
        end

        // trial subtract of one quotient bit
        always_comb
        begin
            trial    = {rem_in[RW-2:0], num_in[B]};
            fits     = (trial >= {1'b0, den_in});
            rem_next = fits ? (trial - {1'b0, den_in}) : trial;
            quo_next = QW'({quo_in, fits});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (ce)
            begin
                vld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                rem_reg[i] <= rem_next;
                quo_reg[i] <= quo_next;
                num_reg[i] <= num_in;
                den_reg[i] <= den_in;
                tag_reg[i] <= tag_s;
            end
        end
    end

    assign out_vld = vld_reg[QW-1];
    assign quo     = quo_reg[QW-1];
    assign tag_out = tag_reg[QW-1];

endmodule

// ===== sv/hif_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, with a tag line
module hif_sqrt #(
    parameter int XW = 62,
    parameter int RW = 31,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          ce,
    input  logic          in_vld,
    input  logic [XW-1:0] x,
    input  logic [SW-1:0] tag_in,
    output logic          out_vld,
    output logic [RW-1:0] root,
    output logic [SW-1:0] tag_out
);

    localparam int TW = XW + 1;

    logic [XW-1:0] rem_reg  [RW];
    logic [RW-1:0] root_reg [RW];
    logic [SW-1:0] tag_reg  [RW];
    logic          vld_reg  [RW];

    for (genvar i = 0; i < RW; i++)
    begin : g_stage
        localparam int B = RW - 1 - i;
        logic [XW-1:0] rem_in;
        logic [RW-1:0] root_in;
        logic [SW-1:0] tag_s;
        logic          vld_in;
        logic [TW-1:0] trial;
        logic [TW-1:0] diff;
        logic [XW-1:0] rem_next;
        logic [RW-1:0] root_next;
        logic          fits;

        if (i == 0)
        begin : g_first
            assign rem_in  = x;
            assign root_in = '0;
            assign tag_s   = tag_in;
            assign vld_in  = in_vld;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign tag_s   = tag_reg[i-1];
            assign vld_in  = vld_reg[i-1];
        end

        // (r + 2^b)^2 - r^2 = 2^(b+1) r + 2^(2b)
        always_comb
        begin
            trial     = (TW'(root_in) << (B + 1)) + (TW'(1) << (2 * B));
            fits      = ({1'b0, rem_in} >= trial);
            diff      = {1'b0, rem_in} - trial;
            rem_next  = fits ? diff[XW-1:0] : rem_in;
            root_next = fits ? (root_in | (RW'(1) << B)) : root_in;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (ce)
            begin
                vld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                rem_reg[i]  <= rem_next;
                root_reg[i] <= root_next;
                tag_reg[i]  <= tag_s;
            end
        end
    end

    assign out_vld = vld_reg[RW-1];
    assign root    = root_reg[RW-1];
    assign tag_out = tag_reg[RW-1];

endmodule

// ===== sv/hif_side.sv =====
// Per-cell pipeline: velocity, pressure, physical flux and sound speed
module hif_side (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               ce,
    input  logic               in_vld,
    input  logic [17:0]        gamma,
    input  logic [30:0]        rho,
    input  logic signed [31:0] mom,
    input  logic [30:0]        en,
    output logic               out_vld,
    output hif_pkg::side_t     side
);

    typedef struct packed {
        logic [30:0]        rho;
        logic signed [31:0] mom;
        logic [30:0]        en;
    } cell_t;

    typedef struct packed {
        logic signed [31:0] vel;
        logic signed [31:0] mom;
        logic [30:0]        rho;
        logic [30:0]        en;
        logic               bad;
        logic signed [31:0] f1;
        logic signed [31:0] f2;
    } mid_t;

    typedef struct packed {
        logic big;
        mid_t mid;
    } late_t;

    // velocity divider
    logic [31:0] mom_mag;
    logic [47:0] div1_num;
    cell_t       cell_in;
    cell_t       cell_q;
    logic        div1_vld;
    logic [47:0] div1_quo;

    assign mom_mag  = mom[31] ? 32'(-mom) : 32'(mom);
    assign div1_num = {mom_mag, 16'h0000};
    assign cell_in  = '{rho: rho, mom: mom, en: en};

    hif_div #(
        .NW(48),
        .DW(31),
        .QW(48),
        .SW($bits(cell_t))
    ) u_div_vel (
        .clk    (clk),
        .rst_n  (rst_n),
        .ce     (ce),
        .in_vld (in_vld),
        .num    (div1_num),
        .den    (rho),
        .tag_in (cell_in),
        .out_vld(div1_vld),
        .quo    (div1_quo),
        .tag_out(cell_q)
    );

    // stage valid bits, A to G
    logic [6:0] vld_reg;

    logic signed [31:0] vel_a_next, vel_a_reg, vel_b_reg, vel_c_reg, vel_d_reg;
    logic signed [31:0] vel_e_reg, vel_f_reg, vel_g_reg;
    cell_t              cell_a_reg, cell_b_reg, cell_c_reg, cell_d_reg;
    cell_t              cell_e_reg, cell_f_reg, cell_g_reg;
    logic signed [63:0] mv_b_next, mv_b_reg;
    logic signed [47:0] diff_c_next, diff_c_reg;
    logic signed [47:0] mv16_c_next, mv16_c_reg, mv16_d_reg, mv16_e_reg;
    logic signed [18:0] g1;
    logic signed [42:0] ph_d_next, ph_d_reg;
    logic signed [43:0] pl_d_next, pl_d_reg;
    logic signed [67:0] prod_e;
    logic signed [31:0] p_e_next, p_e_reg;
    logic signed [50:0] gp_f_next, gp_f_reg, gp_g_reg;
    logic               bad_f_next, bad_f_reg, bad_g_reg;
    logic signed [31:0] f1_f_next, f1_f_reg, f1_g_reg;
    logic signed [32:0] ep_f_next, ep_f_reg;
    logic signed [64:0] vep_g_next, vep_g_reg;

    // A: sign and clamp of the velocity quotient
    always_comb
    begin
        if (cell_q.rho == '0)
        begin
            vel_a_next = '0;
        end
        else if (!cell_q.mom[31])
        begin
            vel_a_next = (div1_quo > 48'h7FFF_FFFF) ? hif_pkg::INT32_MAX
                                                   : $signed(div1_quo[31:0]);
        end
        else
        begin
            vel_a_next = (div1_quo > 48'h8000_0000) ? hif_pkg::INT32_MIN
                                                   : $signed(32'(-div1_quo[31:0]));
        end
    end

    // B to G: kinetic term, pressure, gamma*p, fluxes
    assign g1 = $signed({1'b0, gamma}) - $signed(19'(hif_pkg::Q_ONE));

    always_comb
    begin
        mv_b_next   = vel_a_reg * cell_a_reg.mom;
        diff_c_next = $signed({17'b0, cell_b_reg.en}) - 48'(mv_b_reg >>> 17);
        mv16_c_next = 48'(mv_b_reg >>> 16);
        ph_d_next   = $signed(diff_c_reg[47:24]) * g1;
        pl_d_next   = $signed({1'b0, diff_c_reg[23:0]}) * g1;
        prod_e      = (68'(ph_d_reg) <<< 24) + 68'(pl_d_reg);
        p_e_next    = hif_pkg::sat32(72'(prod_e >>> 16));
        gp_f_next   = $signed({1'b0, gamma}) * p_e_reg;
        bad_f_next  = (cell_e_reg.rho == '0) || (p_e_reg <= 32'sd0);
        f1_f_next   = hif_pkg::sat32(72'(mv16_e_reg) + 72'(p_e_reg));
        ep_f_next   = $signed({2'b00, cell_e_reg.en}) + 33'(p_e_reg);
        vep_g_next  = vel_f_reg * ep_f_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= {vld_reg[5:0], div1_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            vel_a_reg  <= vel_a_next;
            cell_a_reg <= cell_q;
            vel_b_reg  <= vel_a_reg;
            cell_b_reg <= cell_a_reg;
            mv_b_reg   <= mv_b_next;
            vel_c_reg  <= vel_b_reg;
            cell_c_reg <= cell_b_reg;
            diff_c_reg <= diff_c_next;
            mv16_c_reg <= mv16_c_next;
            vel_d_reg  <= vel_c_reg;
            cell_d_reg <= cell_c_reg;
            ph_d_reg   <= ph_d_next;
            pl_d_reg   <= pl_d_next;
            mv16_d_reg <= mv16_c_reg;
            vel_e_reg  <= vel_d_reg;
            cell_e_reg <= cell_d_reg;
            p_e_reg    <= p_e_next;
            mv16_e_reg <= mv16_d_reg;
            vel_f_reg  <= vel_e_reg;
            cell_f_reg <= cell_e_reg;
            gp_f_reg   <= gp_f_next;
            bad_f_reg  <= bad_f_next;
            f1_f_reg   <= f1_f_next;
            ep_f_reg   <= ep_f_next;
            vel_g_reg  <= vel_f_reg;
            cell_g_reg <= cell_f_reg;
            gp_g_reg   <= gp_f_reg;
            bad_g_reg  <= bad_f_reg;
            f1_g_reg   <= f1_f_reg;
            vep_g_reg  <= vep_g_next;
        end
    end

    // H: energy flux, then gamma*p/rho
    mid_t        mid_h;
    mid_t        mid_q;
    logic        div2_vld;
    logic [49:0] div2_quo;

    always_comb
    begin
        mid_h.vel = vel_g_reg;
        mid_h.mom = cell_g_reg.mom;
        mid_h.rho = cell_g_reg.rho;
        mid_h.en  = cell_g_reg.en;
        mid_h.bad = bad_g_reg;
        mid_h.f1  = f1_g_reg;
        mid_h.f2  = hif_pkg::sat32(72'(vep_g_reg >>> 16));
    end

    hif_div #(
        .NW(50),
        .DW(31),
        .QW(50),
        .SW($bits(mid_t))
    ) u_div_snd (
        .clk    (clk),
        .rst_n  (rst_n),
        .ce     (ce),
        .in_vld (vld_reg[6]),
        .num    (gp_g_reg[49:0]),
        .den    (cell_g_reg.rho),
        .tag_in (mid_h),
        .out_vld(div2_vld),
        .quo    (div2_quo),
        .tag_out(mid_q)
    );

    // I: root of q scaled by 2^16
    late_t       late_i;
    late_t       late_q;
    logic [61:0] sqrt_x;
    logic [30:0] root;

    assign late_i = '{big: (div2_quo[49:46] != '0), mid: mid_q};
    assign sqrt_x = {div2_quo[45:0], 16'h0000};

    hif_sqrt #(
        .XW(62),
        .RW(31),
        .SW($bits(late_t))
    ) u_sqrt (
        .clk    (clk),
        .rst_n  (rst_n),
        .ce     (ce),
        .in_vld (div2_vld),
        .x      (sqrt_x),
        .tag_in (late_i),
        .out_vld(out_vld),
        .root   (root),
        .tag_out(late_q)
    );

    // sound speed, zero for a bad state
    always_comb
    begin
        side.vel = late_q.mid.vel;
        side.mom = late_q.mid.mom;
        side.rho = late_q.mid.rho;
        side.en  = late_q.mid.en;
        side.f1  = late_q.mid.f1;
        side.f2  = late_q.mid.f2;
        side.bad = late_q.mid.bad;
        if (late_q.mid.bad)
        begin
            side.snd = '0;
        end
        else if (late_q.big)
        begin
            side.snd = hif_pkg::INT32_MAX;
        end
        else
        begin
            side.snd = $signed({1'b0, root});
        end
    end

endmodule

// ===== sv/hif_comb.sv =====
// Wave-speed bounds and HLL flux from the two cell results
module hif_comb (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             ce,
    input  logic             in_vld,
    input  hif_pkg::side_t   left,
    input  hif_pkg::side_t   right,
    output logic             out_vld,
    output hif_pkg::result_t res
);

    typedef struct packed {
        logic                  wneg;
        hif_pkg::upwind_t      kase;
        logic signed [31:0]    sl;
        logic signed [31:0]    sr;
        logic                  bad;
        logic [2:0][31:0]      fl;
        logic [2:0][31:0]      fr;
        logic [2:0][32:0]      du;
    } ctag_t;

    logic [2:0] vld_c_reg;
    logic [1:0] vld_d_reg;

    // C0: bounds
    logic signed [31:0] vmin, vmax, cmax;
    logic signed [31:0] sl_next, sr_next, sl_c0_reg, sr_c0_reg;
    hif_pkg::side_t     left_c0_reg, right_c0_reg;

    always_comb
    begin
        vmin    = (left.vel < right.vel) ? left.vel : right.vel;
        vmax    = (left.vel > right.vel) ? left.vel : right.vel;
        cmax    = (left.snd > right.snd) ? left.snd : right.snd;
        sl_next = hif_pkg::sat32(72'(vmin) - 72'(cmax));
        sr_next = hif_pkg::sat32(72'(vmax) + 72'(cmax));
    end

    // C1: upwind case, products, state jumps
    hif_pkg::upwind_t   kase_next, kase_c1_reg, kase_c2_reg;
    logic signed [32:0] den_next, den_c1_reg, den_c2_reg;
    logic signed [63:0] slsr_next, slsr_c1_reg, slsr_c2_reg;
    logic [2:0][63:0]   a_next, a_c1_reg, b_next, b_c1_reg;
    logic [2:0][31:0]   fl, fr, fl_c1_reg, fr_c1_reg, fl_c2_reg, fr_c2_reg;
    logic [2:0][32:0]   du_next, du_c1_reg, du_c2_reg;
    logic signed [31:0] sl_c1_reg, sr_c1_reg, sl_c2_reg, sr_c2_reg;
    logic               bad_c1_reg, bad_c2_reg;
    logic [2:0][64:0]   n_next, n_c2_reg;

    assign fl = {left_c0_reg.f2, left_c0_reg.f1, left_c0_reg.mom};
    assign fr = {right_c0_reg.f2, right_c0_reg.f1, right_c0_reg.mom};

    always_comb
    begin
        logic signed [63:0] pa;
        logic signed [63:0] pb;
        priority if (sl_c0_reg >= 32'sd0)
        begin
            kase_next = hif_pkg::UPW_LEFT;
        end
        else if (sr_c0_reg >= 32'sd0)
        begin
            kase_next = hif_pkg::UPW_HLL;
        end
        else
        begin
            kase_next = hif_pkg::UPW_RIGHT;
        end
        den_next  = 33'(sr_c0_reg) - 33'(sl_c0_reg);
        slsr_next = sl_c0_reg * sr_c0_reg;
        for (int k = 0; k < 3; k++)
        begin
            pa        = sr_c0_reg * $signed(fl[k]);
            pb        = sl_c0_reg * $signed(fr[k]);
            a_next[k] = pa;
            b_next[k] = pb;
        end
        du_next[0] = $signed({2'b00, right_c0_reg.rho}) - $signed({2'b00, left_c0_reg.rho});
        du_next[1] = 33'(right_c0_reg.mom) - 33'(left_c0_reg.mom);
        du_next[2] = $signed({2'b00, right_c0_reg.en}) - $signed({2'b00, left_c0_reg.en});
        // C2: numerators of the weighted flux
        for (int k = 0; k < 3; k++)
        begin
            n_next[k] = 65'($signed(a_c1_reg[k])) - 65'($signed(b_c1_reg[k]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_c_reg <= '0;
        end
        else if (ce)
        begin
            vld_c_reg <= {vld_c_reg[1:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            sl_c0_reg    <= sl_next;
            sr_c0_reg    <= sr_next;
            left_c0_reg  <= left;
            right_c0_reg <= right;
            kase_c1_reg  <= kase_next;
            den_c1_reg   <= den_next;
            slsr_c1_reg  <= slsr_next;
            a_c1_reg     <= a_next;
            b_c1_reg     <= b_next;
            fl_c1_reg    <= fl;
            fr_c1_reg    <= fr;
            du_c1_reg    <= du_next;
            sl_c1_reg    <= sl_c0_reg;
            sr_c1_reg    <= sr_c0_reg;
            bad_c1_reg   <= left_c0_reg.bad | right_c0_reg.bad;
            kase_c2_reg  <= kase_c1_reg;
            den_c2_reg   <= den_c1_reg;
            slsr_c2_reg  <= slsr_c1_reg;
            n_c2_reg     <= n_next;
            fl_c2_reg    <= fl_c1_reg;
            fr_c2_reg    <= fr_c1_reg;
            du_c2_reg    <= du_c1_reg;
            sl_c2_reg    <= sl_c1_reg;
            sr_c2_reg    <= sr_c1_reg;
            bad_c2_reg   <= bad_c1_reg;
        end
    end

    // C3: magnitudes into the four dividers
    logic [64:0]      wext, wmag;
    logic [2:0][64:0] nmag;
    ctag_t            tag_w, tag_q;
    logic             divw_vld;
    logic [31:0]      quo_w;
    logic [2:0][31:0] quo_p;
    logic [2:0]       neg_q;

    always_comb
    begin
        wext = 65'(slsr_c2_reg);
        wmag = slsr_c2_reg[63] ? 65'(-$signed(wext)) : wext;
        for (int k = 0; k < 3; k++)
        begin
            nmag[k] = n_c2_reg[k][64] ? 65'(-$signed(n_c2_reg[k])) : n_c2_reg[k];
        end
        tag_w.wneg = slsr_c2_reg[63];
        tag_w.kase = kase_c2_reg;
        tag_w.sl   = sl_c2_reg;
        tag_w.sr   = sr_c2_reg;
        tag_w.bad  = bad_c2_reg;
        tag_w.fl   = fl_c2_reg;
        tag_w.fr   = fr_c2_reg;
        tag_w.du   = du_c2_reg;
    end

    hif_div #(
        .NW(65),
        .DW(33),
        .QW(32),
        .SW($bits(ctag_t))
    ) u_div_w (
        .clk    (clk),
        .rst_n  (rst_n),
        .ce     (ce),
        .in_vld (vld_c_reg[2]),
        .num    (wmag),
        .den    (den_c2_reg[32:0]),
        .tag_in (tag_w),
        .out_vld(divw_vld),
        .quo    (quo_w),
        .tag_out(tag_q)
    );

    for (genvar k = 0; k < 3; k++)
    begin : g_part
        hif_div #(
            .NW(65),
            .DW(33),
            .QW(32),
            .SW(1)
        ) u_div_p (
            .clk    (clk),
            .rst_n  (rst_n),
            .ce     (ce),
            .in_vld (vld_c_reg[2]),
            .num    (nmag[k]),
            .den    (den_c2_reg[32:0]),
            .tag_in (n_c2_reg[k][64]),
            .out_vld(),
            .quo    (quo_p[k]),
            .tag_out(neg_q[k])
        );
    end

    // D0: signed quotients; D1: w times state jump
    logic signed [32:0] w_next, w_d0_reg;
    logic [2:0][32:0]   part_next, part_d0_reg, part_d1_reg;
    logic [2:0][65:0]   pr_next, pr_d1_reg;
    ctag_t              tag_d0_reg, tag_d1_reg;

    always_comb
    begin
        logic signed [65:0] pw;
        w_next = tag_q.wneg ? -$signed({1'b0, quo_w}) : $signed({1'b0, quo_w});
        for (int k = 0; k < 3; k++)
        begin
            part_next[k] = neg_q[k] ? -$signed({1'b0, quo_p[k]}) : $signed({1'b0, quo_p[k]});
            pw           = w_d0_reg * $signed(tag_d0_reg.du[k]);
            pr_next[k]   = pw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_d_reg <= '0;
        end
        else if (ce)
        begin
            vld_d_reg <= {vld_d_reg[0], divw_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            w_d0_reg    <= w_next;
            part_d0_reg <= part_next;
            tag_d0_reg  <= tag_q;
            pr_d1_reg   <= pr_next;
            part_d1_reg <= part_d0_reg;
            tag_d1_reg  <= tag_d0_reg;
        end
    end

    // D2: HLL sum and flux selection
    logic [2:0][31:0] hll;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            hll[k] = hif_pkg::sat32(72'($signed(part_d1_reg[k]))
                                    + 72'($signed(pr_d1_reg[k]) >>> 16));
        end
        res.slow = tag_d1_reg.sl;
        res.fast = tag_d1_reg.sr;
        res.kase = tag_d1_reg.kase;
        res.bad  = tag_d1_reg.bad;
        unique case (tag_d1_reg.kase)
            hif_pkg::UPW_LEFT:
            begin
                res.mass     = tag_d1_reg.fl[0];
                res.momentum = tag_d1_reg.fl[1];
                res.energy   = tag_d1_reg.fl[2];
            end
            hif_pkg::UPW_HLL:
            begin
                res.mass     = hll[0];
                res.momentum = hll[1];
                res.energy   = hll[2];
            end
            default:
            begin
                res.mass     = tag_d1_reg.fr[0];
                res.momentum = tag_d1_reg.fr[1];
                res.energy   = tag_d1_reg.fr[2];
            end
        endcase
    end

    assign out_vld = vld_d_reg[1];

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the HLL interface flux block
module tb;

    localparam int LATENCY    = 174;
    localparam int CYCLE_CAP  = 600000;
    localparam int REPORT_MAX = 10;

    typedef struct {
        longint rho, mom, en, vel, prs, snd;
        longint f0, f1, f2;
        bit     bad;
    } cell_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [159:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [17:0]  cfg_data;

    logic [17:0]        gamma_now;
    hif_pkg::result_t   flux_due[$];
    int                 mismatches;
    int                 send_idle;
    int                 recv_idle;
    int                 recv_hold;
    int                 cycles;

    hll_interface_flux_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Clamp to the signed 32-bit range
    function automatic longint clamp32(input logic signed [127:0] x);
        if (x > 128'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (x < -128'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return longint'(x);
    endfunction

    // Integer square root, bit by bit
    function automatic longint root64(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    // Primitive state, sound speed and physical flux of one cell
    function automatic cell_t cell_state(input logic [30:0] rho, input logic [31:0] mom,
                                         input logic [30:0] en, input logic [17:0] gam);
        cell_t  c;
        longint g;
        longint kin;
        longint q;
        g     = longint'({46'd0, gam});
        c.rho = longint'({33'd0, rho});
        c.mom = longint'($signed(mom));
        c.en  = longint'({33'd0, en});
        c.vel = (c.rho != 0) ? clamp32((c.mom * 65536) / c.rho) : 0;
        kin   = (c.mom * c.vel) >>> 17;
        c.prs = clamp32(((c.en - kin) * (g - 65536)) >>> 16);
        c.bad = (c.rho == 0) || (c.prs <= 0);
        if (c.bad)
        begin
            c.snd = 0;
        end
        else
        begin
            q = (g * c.prs) / c.rho;
            c.snd = (q >= (64'sd1 <<< 46)) ? 64'sd2147483647 : root64(q << 16);
        end
        c.f0 = c.mom;
        c.f1 = clamp32(((c.mom * c.vel) >>> 16) + c.prs);
        c.f2 = clamp32((c.vel * (c.en + c.prs)) >>> 16);
        return c;
    endfunction

    // HLL flux of one interface at the given gamma
    function automatic hif_pkg::result_t hll_flux(input logic [191:0] d,
                                                  input logic [17:0] gam);
        cell_t                lc;
        cell_t                rc;
        hif_pkg::result_t     r;
        longint               cmax;
        longint               sl;
        longint               sr;
        longint               fl[3];
        longint               fr[3];
        longint               ul[3];
        longint               ur[3];
        longint               res[3];
        logic signed [127:0]  num;
        logic signed [127:0]  den;
        logic signed [127:0]  w;
        lc   = cell_state(d[30:0], d[62:31], d[93:63], gam);
        rc   = cell_state(d[124:94], d[156:125], d[187:157], gam);
        cmax = (lc.snd > rc.snd) ? lc.snd : rc.snd;
        sl   = clamp32(((lc.vel < rc.vel) ? lc.vel : rc.vel) - cmax);
        sr   = clamp32(((lc.vel > rc.vel) ? lc.vel : rc.vel) + cmax);
        fl[0] = lc.f0; fl[1] = lc.f1; fl[2] = lc.f2;
        fr[0] = rc.f0; fr[1] = rc.f1; fr[2] = rc.f2;
        ul[0] = lc.rho; ul[1] = lc.mom; ul[2] = lc.en;
        ur[0] = rc.rho; ur[1] = rc.mom; ur[2] = rc.en;
        if (sl >= 0)
        begin
            r.kase = hif_pkg::UPW_LEFT;
            res = fl;
        end
        else if (sr >= 0)
        begin
            r.kase = hif_pkg::UPW_HLL;
            den = sr - sl;
            w   = (128'(sl) * 128'(sr)) / den;
            for (int k = 0; k < 3; k++)
            begin
                num    = 128'(sr) * 128'(fl[k]) - 128'(sl) * 128'(fr[k]);
                res[k] = clamp32(num / den + ((w * 128'(ur[k] - ul[k])) >>> 16));
            end
        end
        else
        begin
            r.kase = hif_pkg::UPW_RIGHT;
            res = fr;
        end
        r.mass     = res[0][31:0];
        r.momentum = res[1][31:0];
        r.energy   = res[2][31:0];
        r.slow     = sl[31:0];
        r.fast     = sr[31:0];
        r.bad      = lc.bad | rc.bad;
        return r;
    endfunction

    // Result checker
    always @(posedge clk)
    begin
        hif_pkg::result_t want;
        hif_pkg::result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.mass     = m_tdata[31:0];
            got.momentum = m_tdata[63:32];
            got.energy   = m_tdata[95:64];
            got.slow     = m_tdata[127:96];
            got.fast     = m_tdata[159:128];
            got.kase     = hif_pkg::upwind_t'(m_tuser[1:0]);
            got.bad      = m_tuser[2];
            if (flux_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                begin
                    $display("tb: unexpected result transaction %h %h", m_tdata, m_tuser);
                end
            end
            else
            begin
                want = flux_due.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                    begin
                        $display("tb: mismatch mass %h/%h mom %h/%h en %h/%h",
                                 want.mass, got.mass, want.momentum, got.momentum,
                                 want.energy, got.energy);
                        $display("tb:   slow %h/%h fast %h/%h case %0d/%0d bad %b/%b",
                                 want.slow, got.slow, want.fast, got.fast,
                                 want.kase, got.kase, want.bad, got.bad);
                    end
                end
            end
        end
    end

    // Receiver readiness, with an optional long hold-off
    always @(negedge clk)
    begin
        if (recv_hold > 0)
        begin
            m_tready  <= 1'b0;
            recv_hold <= recv_hold - 1;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Offer one interface; called at a falling edge, returns at a falling edge
    task automatic send_item(input logic [30:0] lr, input logic [31:0] lm,
                             input logic [30:0] le, input logic [30:0] rr,
                             input logic [31:0] rm, input logic [30:0] re);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, re, rm, rr, le, lm, lr};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        flux_due.push_back(hll_flux({4'd0, re, rm, rr, le, lm, lr}, gamma_now));
        @(negedge clk);
    endtask

    // Stop offering and let the pipeline drain
    task automatic drain();
        s_tvalid <= 1'b0;
        while (flux_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (LATENCY + 10) @(negedge clk);
    endtask

    // Write gamma while the block is idle
    task automatic write_gamma(input logic [17:0] g);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= g;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        gamma_now = g;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // A physically sensible interface with random content
    task automatic send_physical();
        logic [30:0] lr, le, rr, re;
        logic [31:0] lm, rm;
        int          sh;
        sh = $urandom_range(18, 10);
        lr = 31'($urandom_range(1 << sh, 1));
        rr = 31'($urandom_range(1 << sh, 1));
        lm = $urandom_range(1 << sh) - (1 << (sh - 1));
        rm = $urandom_range(1 << sh) - (1 << (sh - 1));
        le = 31'($urandom_range(1 << (sh + 4), 1 << sh));
        re = 31'($urandom_range(1 << (sh + 4), 1 << sh));
        send_item(lr, lm, le, rr, rm, re);
    endtask

    // Any field pattern at all
    task automatic send_noise();
        send_item(31'($urandom), $urandom, 31'($urandom),
                  31'($urandom), $urandom, 31'($urandom));
    endtask

    // Field extremes, upwind cases and bad states
    task automatic test_directed();
        send_item(31'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
                  31'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF);
        send_item(31'd0, 32'd0, 31'd0, 31'd0, 32'd0, 31'd0);
        send_item(31'd0, 32'h8000_0000, 31'h7FFF_FFFF, 31'd1, 32'h7FFF_FFFF, 31'd0);
        send_item(31'd1, 32'h7FFF_FFFF, 31'd0, 31'h7FFF_FFFF, 32'h8000_0000, 31'd1);
        // still gas on both sides: intermediate flux
        send_item(31'h1_0000, 32'd0, 31'h4_0000, 31'h1_0000, 32'd0, 31'h2_0000);
        // strong flow to the right: left flux
        send_item(31'h1_0000, 32'h20_0000, 31'h240_0000,
                  31'h1_0000, 32'h20_0000, 31'h240_0000);
        // strong flow to the left: right flux
        send_item(31'h1_0000, 32'hFFE0_0000, 31'h240_0000,
                  31'h1_0000, 32'hFFE0_0000, 31'h240_0000);
        // kinetic energy above total: non-positive pressure
        send_item(31'h1_0000, 32'h10_0000, 31'h1_0000, 31'h1_0000, 32'd0, 31'h1_0000);
        // huge sound speed
        send_item(31'd1, 32'd0, 31'h7FFF_FFFF, 31'd1, 32'd0, 31'h7FFF_FFFF);
        send_item(31'h7FFF_FFFF, 32'd1, 31'd1, 31'd1, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
        for (int i = 0; i < 6; i++)
        begin
            send_physical();
        end
    endtask

    // Random interfaces: mostly sensible gas, some noise
    task automatic test_random(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 80)
            begin
                send_physical();
            end
            else
            begin
                send_noise();
            end
        end
    endtask

    // Long receiver hold-off fills the pipeline, then a full pause
    task automatic test_backpressure();
        recv_hold = 400;
        test_random(250);
        s_tvalid <= 1'b0;
        while (flux_due.size() != 0)
        begin
            @(negedge clk);
        end
        test_random(30);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        gamma_now  = hif_pkg::GAMMA_RESET;
        mismatches = 0;
        send_idle  = 21;
        recv_idle  = 75;
        recv_hold  = 0;
        cycles     = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(300);
        write_gamma(18'd65537);
        test_directed();
        test_random(150);
        send_idle = 75;
        recv_idle = 21;
        write_gamma(18'd196608);
        test_directed();
        test_random(200);
        write_gamma(18'd65536);
        test_random(60);
        write_gamma(18'd0);
        test_random(60);
        write_gamma(18'h3FFFF);
        test_random(60);
        send_idle = 0;
        recv_idle = 0;
        write_gamma(18'd91750);
        test_backpressure();
        write_gamma(18'($urandom_range(196608, 65537)));
        test_random(392);
        drain();

        if (mismatches == 0 && flux_due.size() == 0)
        begin
            $display("tb: PASS");
        end
        else
        begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/hif_pkg.sv
sv/hif_div.sv
sv/hif_sqrt.sv
sv/hif_side.sv
sv/hif_comb.sv
sv/hll_interface_flux_top.sv
verif/tb.sv
